FILE: src/gvn_pkg.sv
// Shared constants and codes of the grid vertex normal unit.
`default_nettype none
package gvn_pkg;
  localparam int unsigned GRID_SIDE_DEF = 256;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] REG_VERTS_X      = 2'd0;
  localparam logic [1:0] REG_VERTS_Z      = 2'd1;
  localparam logic [1:0] REG_CELL_SIZE    = 2'd2;
  localparam logic [1:0] REG_HEIGHT_SCALE = 2'd3;

  localparam logic [8:0]  VERTS_RST = 9'd256;
  localparam logic [15:0] CELL_RST  = 16'd256;
  localparam logic [15:0] SCALE_RST = 16'd256;

  localparam int unsigned MAG_W = 56;
  localparam logic [15:0] ONE_Q14 = 16'd16384;
endpackage
`default_nettype wire

FILE: src/gvn_mul.sv
// Shared 32x32 unsigned multiplier with registered product.
`default_nettype none
module gvn_mul (
  input  wire logic        clk_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic      [63:0] p_o
);
  always_ff @(posedge clk_i) begin
    p_o <= 64'(a_i) * 64'(b_i);
  end
endmodule
`default_nettype wire

FILE: src/grid_vertex_normal_unit.sv
// Top level: height grid store and vertex normal sequencer.
// A load is written into the height store when it is accepted. A query reads the vertex
// and the corners of its cells, forms the slopes with the multiplier, normalizes by shifts,
// squares, takes a square root and divides per component; a zero sum skips to the output.
// Throughput: one query at a time; the input is not ready until its result is taken.
// Reset clears control and sets the configuration to its defaults; the height store is not cleared.
`default_nettype none
module grid_vertex_normal_unit #(
  parameter int unsigned GRID_SIDE = gvn_pkg::GRID_SIDE_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // grid_x, grid_z, height_in
  input  wire logic [0:0]  s_axis_tuser,  // op
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [63:0] m_axis_tdata,  // normal_x, normal_y, normal_z, world_height
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);
  localparam int unsigned Depth    = GRID_SIDE * GRID_SIDE;
  localparam int unsigned AW       = $clog2(Depth);
  localparam int unsigned CoordLim = (GRID_SIDE < 256) ? GRID_SIDE : 256;
  localparam int unsigned MW       = gvn_pkg::MAG_W;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_MUL, S_NORM, S_SQ, S_SQRT, S_DIV, S_OUT
  } state_e;

  state_e state_q;
  logic [8:0]  vx_q, vz_q, vxc, vzc;
  logic [15:0] cs_q, hs_q;
  logic [7:0]  qx_q, qz_q;
  logic [3:0]  en_q;
  logic [4:0]  cnt_q;
  logic        rvld_q;
  logic [4:0]  rtag_q;
  logic [15:0] rdata_q;
  logic [15:0] hc_q;
  logic signed [20:0] dx_q, dz_q;
  logic [31:0] cc_q, p_q;
  logic [15:0] wh_q;
  logic [MW-1:0] mag_q [3];
  logic [2:0]  neg_q;
  logic [63:0] l2_q, rem_q, res_q, bit_q;
  logic [30:0] len_q;
  logic [45:0] num_q, dv_q;
  logic [15:0] quo_q;
  logic [1:0]  ci_q;
  logic [15:0] nrm_q [3];
  logic [15:0] mem_q [Depth];

  logic [7:0]  in_x, in_z;
  logic [15:0] in_h;
  logic [AW-1:0] waddr, raddr;
  logic        in_acc;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [2:0]  ntri;
  logic [MW-1:0] mag_or;
  logic [MW-1:0] tsh;
  logic [63:0] trial;
  logic [1:0]  rk, pk, rj, pj;
  logic [4:0]  rt, pt;
  logic [7:0]  cx, cz, ax, az;
  logic        pt1, pt2, dxp, dxm, dzp, dzm;
  logic [20:0] adx, adz;
  logic [15:0] qcl;

  assign in_x = s_axis_tdata[7:0];
  assign in_z = s_axis_tdata[15:8];
  assign in_h = s_axis_tdata[31:16];
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata = {wh_q, nrm_q[2], nrm_q[1], nrm_q[0]};

  always_comb begin
    vxc = vx_q;
    if (vx_q < 9'd2) vxc = 9'd2;
    else if (32'(vx_q) > CoordLim) vxc = 9'(CoordLim);
    vzc = vz_q;
    if (vz_q < 9'd2) vzc = 9'd2;
    else if (32'(vz_q) > CoordLim) vzc = 9'(CoordLim);
  end

  assign waddr = AW'(32'(in_z) * GRID_SIDE + 32'(in_x));
  assign ntri = {2'b0, en_q[0]} + {2'b0, en_q[0]} + {2'b0, en_q[1]}
              + {2'b0, en_q[2]} + {2'b0, en_q[2]} + {2'b0, en_q[3]};

  // read address: tag 0 is the vertex itself, then four corners of each cell
  always_comb begin
    rt = cnt_q - 5'd1;
    rk = rt[3:2];
    rj = rt[1:0];
    cx = (rk == 2'd1 || rk == 2'd2) ? qx_q - 8'd1 : qx_q;
    cz = (rk[1]) ? qz_q - 8'd1 : qz_q;
    ax = cx + {7'b0, (rj == 2'd1 || rj == 2'd2)};
    az = cz + {7'b0, rj[1]};
    if (cnt_q == 5'd0 || !en_q[rk]) begin
      ax = qx_q;
      az = qz_q;
    end
    raddr = AW'(32'(az) * GRID_SIDE + 32'(ax));
  end

  // corner weights of the returning read
  always_comb begin
    pt = rtag_q - 5'd1;
    pk = pt[3:2];
    pj = pt[1:0];
    pt1 = (pk != 2'd3);
    pt2 = (pk != 2'd1);
    dxp = 1'b0; dxm = 1'b0; dzp = 1'b0; dzm = 1'b0;
    unique case (pj)
      2'd0: begin dxm = pt1; dzm = pt2; end
      2'd1: begin dxp = pt1; dzm = pt1; end
      2'd2: begin dxp = pt2; dzp = pt1; end
      default: begin dxm = pt2; dzp = pt2; end
    endcase
    if (rtag_q == 5'd0 || !en_q[pk]) begin
      dxp = 1'b0; dxm = 1'b0; dzp = 1'b0; dzm = 1'b0;
    end
  end

  assign adx = dx_q[20] ? 21'(-dx_q) : 21'(dx_q);
  assign adz = dz_q[20] ? 21'(-dz_q) : 21'(dz_q);

  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    if (state_q == S_MUL) begin
      unique case (cnt_q)
        5'd0: begin mul_a = 32'(cs_q); mul_b = 32'(cs_q); end
        5'd1: begin mul_a = 32'(cs_q); mul_b = 32'(hs_q); end
        5'd2: begin mul_a = 32'(hc_q); mul_b = 32'(hs_q); end
        5'd3: begin mul_a = cc_q; mul_b = 32'(ntri); end
        5'd4: begin mul_a = p_q; mul_b = 32'(adx); end
        5'd5: begin mul_a = p_q; mul_b = 32'(adz); end
        default: ;
      endcase
    end else if (state_q == S_SQ && cnt_q < 5'd3) begin
      mul_a = mag_q[cnt_q[1:0]][31:0];
      mul_b = mag_q[cnt_q[1:0]][31:0];
    end
  end

  gvn_mul u_mul (.clk_i(clk_i), .a_i(mul_a), .b_i(mul_b), .p_o(mul_p));

  assign mag_or = mag_q[0] | mag_q[1] | mag_q[2];
  assign tsh = {mul_p[MW-17:0], 16'b0};
  assign trial = res_q + bit_q;
  assign qcl = (quo_q > gvn_pkg::ONE_Q14) ? gvn_pkg::ONE_Q14 : quo_q;

  always_ff @(posedge clk_i) begin
    if (in_acc && s_axis_tuser[0] == gvn_pkg::OP_LOAD
        && 32'(in_x) < GRID_SIDE && 32'(in_z) < GRID_SIDE) begin
      mem_q[waddr] <= in_h;
    end
    rdata_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vx_q <= gvn_pkg::VERTS_RST;
      vz_q <= gvn_pkg::VERTS_RST;
      cs_q <= gvn_pkg::CELL_RST;
      hs_q <= gvn_pkg::SCALE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        gvn_pkg::REG_VERTS_X:   vx_q <= cfg_data_i[8:0];
        gvn_pkg::REG_VERTS_Z:   vz_q <= cfg_data_i[8:0];
        gvn_pkg::REG_CELL_SIZE: cs_q <= cfg_data_i;
        default:                hs_q <= cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= 5'd0;
      rvld_q <= 1'b0;
      ci_q <= 2'd0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_acc && s_axis_tuser[0] == gvn_pkg::OP_QUERY
              && {1'b0, in_x} < vxc && {1'b0, in_z} < vzc) begin
            qx_q <= in_x;
            qz_q <= in_z;
            en_q[0] <= ({1'b0, in_x} + 9'd1 < vxc) && ({1'b0, in_z} + 9'd1 < vzc);
            en_q[1] <= (in_x != 8'd0) && ({1'b0, in_z} + 9'd1 < vzc);
            en_q[2] <= (in_x != 8'd0) && (in_z != 8'd0);
            en_q[3] <= ({1'b0, in_x} + 9'd1 < vxc) && (in_z != 8'd0);
            dx_q <= '0;
            dz_q <= '0;
            cnt_q <= 5'd0;
            rvld_q <= 1'b0;
            state_q <= S_READ;
          end
        end
        S_READ: begin
          rvld_q <= (cnt_q <= 5'd16);
          rtag_q <= cnt_q;
          if (cnt_q <= 5'd16) cnt_q <= cnt_q + 5'd1;
          if (rvld_q) begin
            if (rtag_q == 5'd0) hc_q <= rdata_q;
            if (dxp) dx_q <= dx_q + $signed({5'b0, rdata_q});
            else if (dxm) dx_q <= dx_q - $signed({5'b0, rdata_q});
            if (dzp) dz_q <= dz_q + $signed({5'b0, rdata_q});
            else if (dzm) dz_q <= dz_q - $signed({5'b0, rdata_q});
          end
          if (cnt_q == 5'd17) begin
            cnt_q <= 5'd0;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          cnt_q <= cnt_q + 5'd1;
          unique case (cnt_q)
            5'd1: cc_q <= mul_p[31:0];
            5'd2: p_q <= mul_p[31:0];
            5'd3: wh_q <= mul_p[31:16];
            5'd4: begin
              if (tsh > (MW'(1) << 32)) begin
                mag_q[1] <= tsh - (MW'(1) << 32);
                neg_q[1] <= 1'b1;
              end else begin
                mag_q[1] <= (MW'(1) << 32) - tsh;
                neg_q[1] <= 1'b0;
              end
            end
            5'd5: begin
              mag_q[0] <= mul_p[MW-1:0];
              neg_q[0] <= dx_q[20];
            end
            5'd6: begin
              mag_q[2] <= mul_p[MW-1:0];
              neg_q[2] <= dz_q[20];
              state_q <= S_NORM;
            end
            default: ;
          endcase
        end
        S_NORM: begin
          cnt_q <= 5'd0;
          l2_q <= '0;
          if (mag_or == '0) begin
            nrm_q[0] <= '0;
            nrm_q[1] <= '0;
            nrm_q[2] <= '0;
            state_q <= S_OUT;
          end else if (|mag_or[MW-1:30]) begin
            for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
          end else if (!mag_or[29]) begin
            for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] << 1;
          end else begin
            state_q <= S_SQ;
          end
        end
        S_SQ: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q != 5'd0) l2_q <= l2_q + mul_p;
          if (cnt_q == 5'd3) begin
            rem_q <= l2_q + mul_p;
            res_q <= '0;
            bit_q <= 64'd1 << 62;
            state_q <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (bit_q != '0) begin
            if (rem_q >= trial) begin
              rem_q <= rem_q - trial;
              res_q <= (res_q >> 1) + bit_q;
            end else begin
              res_q <= res_q >> 1;
            end
            bit_q <= bit_q >> 2;
          end else begin
            len_q <= res_q[30:0];
            ci_q <= 2'd0;
            cnt_q <= 5'd0;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd0) begin
            num_q <= {2'b0, mag_q[ci_q][29:0], 14'b0} + 46'(len_q >> 1);
            dv_q <= {len_q, 15'b0};
            quo_q <= '0;
          end else if (cnt_q <= 5'd16) begin
            if (num_q >= dv_q) begin
              num_q <= num_q - dv_q;
              quo_q <= {quo_q[14:0], 1'b1};
            end else begin
              quo_q <= {quo_q[14:0], 1'b0};
            end
            dv_q <= dv_q >> 1;
          end else begin
            nrm_q[ci_q] <= neg_q[ci_q] ? 16'(-qcl) : qcl;
            cnt_q <= 5'd0;
            ci_q <= ci_q + 2'd1;
            if (ci_q == 2'd2) state_q <= S_OUT;
          end
        end
        default: begin
          if (m_axis_tready) state_q <= S_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: src/gvn_checker.sv
// Port-level checks of the grid vertex normal unit, bound to the top level.
`default_nettype none
module gvn_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [63:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word dropped or changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input taken while a result waits");

  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
    else $error("more than one result for a query");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $signed(m_axis_tdata[15:0]) <= 16'sd16384
      && $signed(m_axis_tdata[15:0]) >= -16'sd16384
      && $signed(m_axis_tdata[31:16]) <= 16'sd16384
      && $signed(m_axis_tdata[31:16]) >= -16'sd16384
      && $signed(m_axis_tdata[47:32]) <= 16'sd16384
      && $signed(m_axis_tdata[47:32]) >= -16'sd16384)
    else $error("normal component out of range");
endmodule

bind grid_vertex_normal_unit gvn_checker u_gvn_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
